@@ rtl/rvsd_pkg.sv @@
// rvsd_pkg: shared types, encoding table and codes for the rv64 subset decoder
package rvsd_pkg;

  localparam int unsigned NUM_OPS = 31;

  localparam logic [4:0] OP_UNKNOWN = 5'd31;

  localparam logic [2:0] CLASS_ALU     = 3'd0;
  localparam logic [2:0] CLASS_FPU     = 3'd1;
  localparam logic [2:0] CLASS_LDST    = 3'd2;
  localparam logic [2:0] CLASS_BRANCH  = 3'd3;
  localparam logic [2:0] CLASS_UNKNOWN = 3'd4;

  // one mask/match encoding and its class
  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] match;
    logic [2:0]  cls;
  } rvsd_enc_t;

  // entry index is the dense opcode, lowest index wins
  localparam rvsd_enc_t ENC_TABLE [NUM_OPS] = '{
    '{32'hfe00707f, 32'h00000033, CLASS_ALU},     // add
    '{32'h0000707f, 32'h00000013, CLASS_ALU},     // addi
    '{32'h0000707f, 32'h0000001b, CLASS_ALU},     // addiw
    '{32'hfe00707f, 32'h0000003b, CLASS_ALU},     // addw
    '{32'h0000007f, 32'h00000017, CLASS_BRANCH},  // auipc
    '{32'h0000707f, 32'h00000063, CLASS_BRANCH},  // beq
    '{32'h0000707f, 32'h00007063, CLASS_BRANCH},  // bgeu
    '{32'h0000707f, 32'h00006063, CLASS_BRANCH},  // bltu
    '{32'h0000707f, 32'h00001063, CLASS_BRANCH},  // bne
    '{32'hfe00007f, 32'h10000053, CLASS_FPU},     // fmul.s
    '{32'h0000707f, 32'h00002007, CLASS_LDST},    // flw
    '{32'h0600007f, 32'h00000043, CLASS_FPU},     // fmadd.s
    '{32'h0000707f, 32'h00002027, CLASS_LDST},    // fsw
    '{32'h0000707f, 32'h00003003, CLASS_LDST},    // ld
    '{32'h0000007f, 32'h00000037, CLASS_LDST},    // lui
    '{32'h0000707f, 32'h00002003, CLASS_LDST},    // lw
    '{32'h0000707f, 32'h00006003, CLASS_LDST},    // lwu
    '{32'hfe00707f, 32'h02000033, CLASS_ALU},     // mul
    '{32'hfe00707f, 32'h0200003b, CLASS_ALU},     // mulw
    '{32'h0000707f, 32'h00002023, CLASS_LDST},    // sw
    '{32'hfe00707f, 32'h00003033, CLASS_ALU},     // sltu
    '{32'hfe00707f, 32'h0000101b, CLASS_ALU},     // slliw
    '{32'hfc00707f, 32'h00001013, CLASS_ALU},     // slli
    '{32'hfe00707f, 32'h00002033, CLASS_ALU},     // slt
    '{32'h0000007f, 32'h0000006f, CLASS_BRANCH},  // jal
    '{32'h0000707f, 32'h00000067, CLASS_BRANCH},  // jalr
    '{32'h0000707f, 32'h00003023, CLASS_LDST},    // sd
    '{32'h0000707f, 32'h00007013, CLASS_ALU},     // andi
    '{32'h0000707f, 32'h00006013, CLASS_ALU},     // ori
    '{32'h0000707f, 32'h00004013, CLASS_ALU},     // xori
    '{32'hfe00707f, 32'h00006033, CLASS_ALU}      // or
  };

  // opcode lookup result
  typedef struct packed {
    logic [4:0] op_id;
    logic [2:0] op_class;
  } rvsd_dec_t;

  // register fields and immediates taken straight from the word
  typedef struct packed {
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [4:0]         src3_reg;
    logic signed [31:0] upper_imm;
    logic signed [11:0] short_imm;
    logic signed [11:0] store_imm;
    logic signed [12:0] branch_imm;
    logic signed [20:0] jump_imm;
  } rvsd_fields_t;

  // complete decoded item
  typedef struct packed {
    logic [31:0]  raw_word;
    rvsd_dec_t    dec;
    rvsd_fields_t fields;
  } rvsd_result_t;

endpackage

@@ rtl/rvsd_match.sv @@
// rvsd_match: mask/match lookup of the instruction word, first hit wins
module rvsd_match
  import rvsd_pkg::*;
(
  input  logic [31:0] word,
  output rvsd_dec_t   dec
);

  logic [NUM_OPS-1:0] hit;

  // compare against every table entry in parallel
  always_comb begin
    for (int i = 0; i < NUM_OPS; i++) begin
      hit[i] = ((word & ENC_TABLE[i].mask) == ENC_TABLE[i].match);
    end
  end

  // priority select, scanning from the top so the lowest index ends up chosen
  always_comb begin
    dec.op_id    = OP_UNKNOWN;
    dec.op_class = CLASS_UNKNOWN;
    for (int i = NUM_OPS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        dec.op_id    = 5'(i);
        dec.op_class = ENC_TABLE[i].cls;
      end
    end
  end

endmodule

@@ rtl/rvsd_fields.sv @@
// rvsd_fields: register index and immediate extraction for all formats
module rvsd_fields
  import rvsd_pkg::*;
(
  input  logic [31:0]  word,
  output rvsd_fields_t fields
);

  // register indices
  assign fields.dest_reg = word[11:7];
  assign fields.src1_reg = word[19:15];
  assign fields.src2_reg = word[24:20];
  assign fields.src3_reg = word[31:27];

  // u, i and s formats
  assign fields.upper_imm = {word[31:12], 12'b0};
  assign fields.short_imm = word[31:20];
  assign fields.store_imm = {word[31:25], word[11:7]};

  // b and j formats, even offsets
  assign fields.branch_imm = {word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign fields.jump_imm   = {word[31], word[19:12], word[20], word[30:21], 1'b0};

endmodule

@@ rtl/rv64_subset_instruction_decoder.sv @@
// rv64_subset_instruction_decoder: registered decoder for an rv64 i/m/f subset
// path: an accepted item passes the input register, then the result register, to out_tvalid
// throughput: one item per cycle while out_tready is high; the decode between the two registers is a single pass
// both register stages advance while the result side drains, so stalls cost no gaps
// reset: synchronous active-low rst_n clears both stage valids; payloads are not reset
module rv64_subset_instruction_decoder
  import rvsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] instruction_word
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] raw_word, [36:32] op_id, [39:37] op_class, [44:40] dest_reg,
  // [49:45] src1_reg, [54:50] src2_reg, [59:55] src3_reg, [91:60] upper_imm,
  // [103:92] short_imm, [115:104] store_imm, [128:116] branch_imm,
  // [149:129] jump_imm, [151:150] zero
  output logic [151:0] out_tdata
);

  logic         in_valid_r;
  logic         in_valid_nxt;
  logic [31:0]  word_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  rvsd_result_t res_r;
  rvsd_result_t res_nxt;
  rvsd_dec_t    dec;
  rvsd_fields_t fields;
  logic         res_load;
  logic         in_load;

  // stage handshakes
  assign res_load  = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || res_load;
  assign in_load   = in_tvalid && in_tready;

  // decode logic between the registers
  rvsd_match u_match (
    .word (word_r),
    .dec  (dec)
  );

  rvsd_fields u_fields (
    .word   (word_r),
    .fields (fields)
  );

  always_comb begin
    res_nxt.raw_word = word_r;
    res_nxt.dec      = dec;
    res_nxt.fields   = fields;
  end

  // valid flags for both stages
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_load) begin
      word_r <= in_tdata;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  // result packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       res_r.fields.jump_imm,
                       res_r.fields.branch_imm,
                       res_r.fields.store_imm,
                       res_r.fields.short_imm,
                       res_r.fields.upper_imm,
                       res_r.fields.src3_reg,
                       res_r.fields.src2_reg,
                       res_r.fields.src1_reg,
                       res_r.fields.dest_reg,
                       res_r.dec.op_class,
                       res_r.dec.op_id,
                       res_r.raw_word};

  // unknown opcode and unknown class always travel together
  a_unknown_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.dec.op_id == OP_UNKNOWN) == (res_r.dec.op_class == CLASS_UNKNOWN)))
    else $error("op_id and op_class disagree on unknown");

  // a held input item is moved to the result stage when that stage frees up
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && (!out_valid_r || out_tready)) |=> out_valid_r)
    else $error("input stage did not advance into a free result stage");

  // an accepted item lands in the input stage
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (in_valid_r && word_r == $past(in_tdata)))
    else $error("accepted item not captured");

  // the echoed word matches the extracted dest_reg and src3_reg fields
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.fields.dest_reg == res_r.raw_word[11:7] &&
                     res_r.fields.src3_reg == res_r.raw_word[31:27]))
    else $error("register fields inconsistent with raw word");

endmodule

@@ verif/rv64_subset_instruction_decoder_tb.sv @@
// testbench for the rv64 subset decoder: streamed words, scoreboard predictor and checks
`timescale 1ns / 100ps

module rv64_subset_instruction_decoder_tb;
  import rvsd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 80;
  localparam int RANDOM_WORDS  = 400;
  localparam int NUM_ENCODINGS = 31;

  // encoding map, index is the dense opcode, first hit wins
  localparam rvsd_enc_t OPCODE_MAP [NUM_ENCODINGS] = '{
    '{32'hfe00707f, 32'h00000033, CLASS_ALU},     // add
    '{32'h0000707f, 32'h00000013, CLASS_ALU},     // addi
    '{32'h0000707f, 32'h0000001b, CLASS_ALU},     // addiw
    '{32'hfe00707f, 32'h0000003b, CLASS_ALU},     // addw
    '{32'h0000007f, 32'h00000017, CLASS_BRANCH},  // auipc
    '{32'h0000707f, 32'h00000063, CLASS_BRANCH},  // beq
    '{32'h0000707f, 32'h00007063, CLASS_BRANCH},  // bgeu
    '{32'h0000707f, 32'h00006063, CLASS_BRANCH},  // bltu
    '{32'h0000707f, 32'h00001063, CLASS_BRANCH},  // bne
    '{32'hfe00007f, 32'h10000053, CLASS_FPU},     // fmul.s
    '{32'h0000707f, 32'h00002007, CLASS_LDST},    // flw
    '{32'h0600007f, 32'h00000043, CLASS_FPU},     // fmadd.s
    '{32'h0000707f, 32'h00002027, CLASS_LDST},    // fsw
    '{32'h0000707f, 32'h00003003, CLASS_LDST},    // ld
    '{32'h0000007f, 32'h00000037, CLASS_LDST},    // lui
    '{32'h0000707f, 32'h00002003, CLASS_LDST},    // lw
    '{32'h0000707f, 32'h00006003, CLASS_LDST},    // lwu
    '{32'hfe00707f, 32'h02000033, CLASS_ALU},     // mul
    '{32'hfe00707f, 32'h0200003b, CLASS_ALU},     // mulw
    '{32'h0000707f, 32'h00002023, CLASS_LDST},    // sw
    '{32'hfe00707f, 32'h00003033, CLASS_ALU},     // sltu
    '{32'hfe00707f, 32'h0000101b, CLASS_ALU},     // slliw
    '{32'hfc00707f, 32'h00001013, CLASS_ALU},     // slli
    '{32'hfe00707f, 32'h00002033, CLASS_ALU},     // slt
    '{32'h0000007f, 32'h0000006f, CLASS_BRANCH},  // jal
    '{32'h0000707f, 32'h00000067, CLASS_BRANCH},  // jalr
    '{32'h0000707f, 32'h00003023, CLASS_LDST},    // sd
    '{32'h0000707f, 32'h00007013, CLASS_ALU},     // andi
    '{32'h0000707f, 32'h00006013, CLASS_ALU},     // ori
    '{32'h0000707f, 32'h00004013, CLASS_ALU},     // xori
    '{32'hfe00707f, 32'h00006033, CLASS_ALU}      // or
  };

  // one decoded item as the result channel carries it
  typedef struct {
    logic [31:0]        raw_word;
    logic [4:0]         op_id;
    logic [2:0]         op_class;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [4:0]         src3_reg;
    logic signed [31:0] upper_imm;
    logic signed [11:0] short_imm;
    logic signed [11:0] store_imm;
    logic signed [12:0] branch_imm;
    logic signed [20:0] jump_imm;
    logic [1:0]         pad;
  } decoded_word_t;

  // predicts each accepted word and checks results in order
  class decode_scoreboard;
    decoded_word_t pending_decodes[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function decoded_word_t decode_word(logic [31:0] w);
      decoded_word_t d;
      bit hit;
      hit = 1'b0;
      d.raw_word = w;
      d.op_id    = OP_UNKNOWN;
      d.op_class = CLASS_UNKNOWN;
      // first matching encoding wins
      for (int i = 0; i < NUM_ENCODINGS; i++) begin
        if (!hit && ((w & OPCODE_MAP[i].mask) == OPCODE_MAP[i].match)) begin
          d.op_id    = i[4:0];
          d.op_class = OPCODE_MAP[i].cls;
          hit        = 1'b1;
        end
      end
      // fields are taken from every word, matched or not
      d.dest_reg   = w[11:7];
      d.src1_reg   = w[19:15];
      d.src2_reg   = w[24:20];
      d.src3_reg   = w[31:27];
      d.upper_imm  = {w[31:12], 12'b0};
      d.short_imm  = w[31:20];
      d.store_imm  = {w[31:25], w[11:7]};
      d.branch_imm = {w[31], w[7], w[30:25], w[11:8], 1'b0};
      d.jump_imm   = {w[31], w[19:12], w[20], w[30:21], 1'b0};
      d.pad        = 2'b00;
      return d;
    endfunction

    function void note_word(logic [31:0] w);
      pending_decodes.push_back(decode_word(w));
    endfunction

    function int outstanding();
      return pending_decodes.size();
    endfunction

    function void compare_field(logic [31:0] w, string label, logic [31:0] want,
                                logic [31:0] got);
      if (want !== got) begin
        $display("%0t: word %h field %s mismatch, expected %h, actual %h",
                 $time, w, label, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [151:0] data);
      decoded_word_t want;
      if (pending_decodes.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, data);
        errors++;
        return;
      end
      want = pending_decodes.pop_front();
      compare_field(want.raw_word, "raw_word", want.raw_word, data[31:0]);
      compare_field(want.raw_word, "op_id", {27'b0, want.op_id}, {27'b0, data[36:32]});
      compare_field(want.raw_word, "op_class", {29'b0, want.op_class},
                    {29'b0, data[39:37]});
      compare_field(want.raw_word, "dest_reg", {27'b0, want.dest_reg},
                    {27'b0, data[44:40]});
      compare_field(want.raw_word, "src1_reg", {27'b0, want.src1_reg},
                    {27'b0, data[49:45]});
      compare_field(want.raw_word, "src2_reg", {27'b0, want.src2_reg},
                    {27'b0, data[54:50]});
      compare_field(want.raw_word, "src3_reg", {27'b0, want.src3_reg},
                    {27'b0, data[59:55]});
      compare_field(want.raw_word, "upper_imm", want.upper_imm, data[91:60]);
      compare_field(want.raw_word, "short_imm", {20'b0, want.short_imm},
                    {20'b0, data[103:92]});
      compare_field(want.raw_word, "store_imm", {20'b0, want.store_imm},
                    {20'b0, data[115:104]});
      compare_field(want.raw_word, "branch_imm", {19'b0, want.branch_imm},
                    {19'b0, data[128:116]});
      compare_field(want.raw_word, "jump_imm", {11'b0, want.jump_imm},
                    {11'b0, data[149:129]});
      compare_field(want.raw_word, "pad", {30'b0, want.pad}, {30'b0, data[151:150]});
    endfunction
  endclass

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;   // [31:0] instruction_word
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [31:0] raw_word, [36:32] op_id, [39:37] op_class, [44:40] dest_reg,
  // [49:45] src1_reg, [54:50] src2_reg, [59:55] src3_reg, [91:60] upper_imm,
  // [103:92] short_imm, [115:104] store_imm, [128:116] branch_imm,
  // [149:129] jump_imm, [151:150] zero
  logic [151:0] out_tdata;

  decode_scoreboard board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_pending  = 1'b0;
  int hold_left     = 0;
  int cycle_count   = 0;

  rv64_subset_instruction_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_pending) begin
      out_tready   <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_pending <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // handshake monitor
  always @(posedge clk) begin
    if (rst_n && board != null) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if (in_tvalid && in_tready) board.note_word(in_tdata);
    end
  end

  // offer one word, with random gaps ahead of it
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly well-formed encodings with random free bits, the rest pure noise
  function automatic logic [31:0] random_word();
    int idx;
    if ($urandom_range(99) < 70) begin
      idx = $urandom_range(NUM_ENCODINGS - 1);
      return OPCODE_MAP[idx].match | ($urandom() & ~OPCODE_MAP[idx].mask);
    end
    return $urandom();
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  initial begin
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 7;
    recv_idle_pct = 71;

    // directed: extremes, then every encoding with free bits all clear or all set
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    for (int i = 0; i < NUM_ENCODINGS; i++) begin
      if (i % 2 == 0) send_word(OPCODE_MAP[i].match | ~OPCODE_MAP[i].mask);
      else send_word(OPCODE_MAP[i].match);
    end

    send_random(RANDOM_WORDS / 3);

    send_idle_pct = 71;
    recv_idle_pct = 7;
    send_random(RANDOM_WORDS / 3);

    // no idling, with a long receiver hold-off to back up the pipeline
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_pending  = 1'b1;
    send_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
    in_tvalid <= 1'b0;

    // drain
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
